### rtl/pfl_pkg.sv
// Shared types and constants for the page free-list allocator.
package pfl_pkg;

    localparam int NUM_PAGES = 1024;
    localparam int PAGE_W    = 10;
    localparam int LINK_W    = 11;
    localparam int COUNT_W   = 11;
    localparam int STEP_W    = 12;

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_PAGES);

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_INIT  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_RUN  = 2'd1;
    localparam logic [1:0] ST_BAD_ARG = 2'd2;

    localparam logic CFG_FIRST_PAGE = 1'b0;
    localparam logic CFG_LAST_PAGE  = 1'b1;

    typedef struct packed {
        logic [1:0]         action;
        logic [PAGE_W-1:0]  page;
        logic [COUNT_W-1:0] count;
    } pfl_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [PAGE_W-1:0]  page_res;
        logic [COUNT_W-1:0] free_count;
    } pfl_out_t;

endpackage

### rtl/page_free_list_allocator.sv
// Top level of the page free-list allocator: sequencer, link table and result register.

// Each item is worked by one sequencer that owns the write port and the
// registered read port of the link table. Init and free push one page per
// cycle. An alloc walks the free list one link entry per cycle, visits the
// outer state each time a candidate run breaks, and unlinks a found run in
// the inner and unlink states; a failed check goes straight to the response
// state. The input is not ready while an item is at work; the result sits in
// an output register, so a new item is taken while it waits. Configuration
// writes are always accepted and should only be made while the block is idle.
module page_free_list_allocator
    import pfl_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  pfl_in_t        s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output pfl_out_t       m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_index,
    input  logic [PAGE_W-1:0] cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_OUTER  = 6'b000010,
        S_INNER  = 6'b000100,
        S_UNLINK = 6'b001000,
        S_PUSH   = 6'b010000,
        S_RESP   = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [PAGE_W-1:0]    first_reg, last_reg;
    logic [LINK_W-1:0]    head_reg, head_next;
    logic [COUNT_W-1:0]   free_reg, free_next;
    logic [COUNT_W-1:0]   n_reg, n_next;
    logic [COUNT_W-1:0]   len_reg, len_next;
    logic [STEP_W-1:0]    steps_reg, steps_next;
    logic [LINK_W-1:0]    cur_reg, cur_next;
    logic [LINK_W-1:0]    prev_reg, prev_next;
    logic [LINK_W-1:0]    bprev_reg, bprev_next;
    logic [PAGE_W-1:0]    p_reg, p_next;
    logic [PAGE_W-1:0]    end_reg, end_next;
    logic [1:0]           status_reg, status_next;
    logic [PAGE_W-1:0]    res_reg, res_next;
    logic                 m_valid_reg;
    pfl_out_t             m_data_reg;

    // Link table: one write and one registered read per cycle.
    logic [LINK_W-1:0]    link_mem [NUM_PAGES];
    logic                 wr_en;
    logic [PAGE_W-1:0]    wr_addr;
    logic [LINK_W-1:0]    wr_data;
    logic [PAGE_W-1:0]    rd_addr;
    logic [LINK_W-1:0]    rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            link_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= link_mem[rd_addr];
    end

    // Free-argument checks.
    logic [COUNT_W-1:0] cm1;
    logic [COUNT_W-1:0] low_w;
    logic               free_bad;
    logic [COUNT_W:0]   free_sum;
    logic [LINK_W-1:0]  nx;

    assign cm1      = s_data.count - COUNT_W'(1);
    assign low_w    = COUNT_W'(s_data.page) - cm1;
    assign free_bad = (s_data.count == '0) || (cm1 > COUNT_W'(s_data.page))
                      || (low_w < COUNT_W'(first_reg)) || (s_data.page > last_reg);
    assign free_sum = (COUNT_W+1)'(free_reg) + (COUNT_W+1)'(s_data.count);
    assign nx       = rd_data_reg;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Sequencer.
    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        free_next   = free_reg;
        n_next      = n_reg;
        len_next    = len_reg;
        steps_next  = steps_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        bprev_next  = bprev_reg;
        p_next      = p_reg;
        end_next    = end_reg;
        status_next = status_reg;
        res_next    = res_reg;
        wr_en       = 1'b0;
        wr_addr     = p_reg;
        wr_data     = head_reg;
        rd_addr     = cur_reg[PAGE_W-1:0];
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_next    = '0;
                    status_next = ST_OK;
                    state_next  = S_RESP;
                    n_next      = s_data.count;
                    case (s_data.action)
                        ACT_ALLOC: begin
                            if (s_data.count == '0) begin
                                status_next = ST_BAD_ARG;
                            end else if (s_data.count > free_reg) begin
                                status_next = ST_NO_RUN;
                            end else begin
                                cur_next   = head_reg;
                                prev_next  = LINK_NONE;
                                steps_next = '0;
                                state_next = S_OUTER;
                            end
                        end
                        ACT_FREE: begin
                            if (free_bad) begin
                                status_next = ST_BAD_ARG;
                            end else begin
                                p_next     = low_w[PAGE_W-1:0];
                                end_next   = s_data.page;
                                free_next  = (free_sum > (COUNT_W+1)'(NUM_PAGES)) ?
                                             COUNT_W'(NUM_PAGES) : free_sum[COUNT_W-1:0];
                                state_next = S_PUSH;
                            end
                        end
                        ACT_INIT: begin
                            head_next = LINK_NONE;
                            if (first_reg <= last_reg) begin
                                free_next  = COUNT_W'(last_reg) - COUNT_W'(first_reg)
                                             + COUNT_W'(1);
                                p_next     = first_reg;
                                end_next   = last_reg;
                                state_next = S_PUSH;
                            end else begin
                                free_next = '0;
                            end
                        end
                        default: begin
                            status_next = ST_BAD_ARG;
                        end
                    endcase
                end
            end
            S_PUSH: begin
                wr_en     = 1'b1;
                wr_addr   = p_reg;
                wr_data   = head_reg;
                head_next = LINK_W'(p_reg);
                if (p_reg == end_reg) begin
                    state_next = S_RESP;
                end else begin
                    p_next = p_reg + PAGE_W'(1);
                end
            end
            S_OUTER: begin
                if (cur_reg[LINK_W-1] || (steps_reg >= STEP_W'(NUM_PAGES))) begin
                    status_next = ST_NO_RUN;
                    state_next  = S_RESP;
                end else begin
                    bprev_next = prev_reg;
                    res_next   = cur_reg[PAGE_W-1:0];
                    len_next   = COUNT_W'(1);
                    rd_addr    = cur_reg[PAGE_W-1:0];
                    state_next = S_INNER;
                end
            end
            S_INNER: begin
                if (len_reg == n_reg) begin
                    // Run found: splice its successor into the predecessor.
                    if (!bprev_reg[LINK_W-1]) begin
                        wr_en   = 1'b1;
                        wr_addr = bprev_reg[PAGE_W-1:0];
                        wr_data = nx;
                    end else begin
                        head_next = nx;
                    end
                    free_next  = free_reg - n_reg;
                    state_next = S_UNLINK;
                end else if ((steps_reg >= STEP_W'(NUM_PAGES)) || nx[LINK_W-1]
                             || ((nx + LINK_W'(1)) != cur_reg)) begin
                    prev_next  = cur_reg;
                    cur_next   = nx;
                    steps_next = steps_reg + STEP_W'(1);
                    state_next = S_OUTER;
                end else begin
                    prev_next  = cur_reg;
                    cur_next   = nx;
                    len_next   = len_reg + COUNT_W'(1);
                    steps_next = steps_reg + STEP_W'(1);
                    rd_addr    = nx[PAGE_W-1:0];
                end
            end
            S_UNLINK: begin
                wr_en       = 1'b1;
                wr_addr     = cur_reg[PAGE_W-1:0];
                wr_data     = LINK_NONE;
                status_next = ST_OK;
                state_next  = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= LINK_NONE;
            free_reg    <= '0;
            first_reg   <= '0;
            last_reg    <= PAGE_W'(NUM_PAGES - 1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            free_reg  <= free_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_FIRST_PAGE) begin
                    first_reg <= cfg_data;
                end else begin
                    last_reg <= cfg_data;
                end
            end
            if (state_reg == S_RESP && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers and result payload.
    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        len_reg    <= len_next;
        steps_reg  <= steps_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        bprev_reg  <= bprev_next;
        p_reg      <= p_next;
        end_reg    <= end_next;
        status_reg <= status_next;
        res_reg    <= res_next;
        if (state_reg == S_RESP && (!m_valid_reg || m_ready)) begin
            m_data_reg.status     <= status_reg;
            m_data_reg.page_res   <= (status_reg == ST_OK) ? res_reg : '0;
            m_data_reg.free_count <= free_reg;
        end
    end

    // The input is only taken by an idle sequencer.
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_IDLE) else $error("ready outside idle");

    // The free count never passes the number of pages.
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg <= COUNT_W'(NUM_PAGES)) else $error("free count overflow");

    // Unlink only follows a found run.
    a_unlink_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_UNLINK |-> $past(state_reg) == S_INNER)
        else $error("unlink without run");

    // A push sweep never runs past its last page.
    a_push_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_PUSH |-> p_reg <= end_reg) else $error("push overran");

endmodule

### test/page_alloc_checker.sv
// Checker for the page free-list allocator: predicts every result item and compares it.
module page_alloc_checker
    import pfl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  pfl_in_t           s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  pfl_out_t          m_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [PAGE_W-1:0] cfg_data,
    output int                error_count,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the allocator state and its page range.
    int       shadow_link [NUM_PAGES];
    int       shadow_head;
    int       shadow_free;
    int       range_low;
    int       range_high;
    pfl_out_t expected_replies [$];

    assign outstanding = expected_replies.size();

    // Walk the shadow list for n pages that each drop by one; unlink and return the top page.
    function automatic logic [1:0] claim_run(input int n, output int top_page);
        int prev;
        int cur;
        int steps;
        int blk_prev;
        int blk_start;
        int len;
        int nx;
        bit broke;
        prev = NUM_PAGES;
        cur = shadow_head;
        steps = 0;
        top_page = 0;
        if (n == 0) return ST_BAD_ARG;
        if (n > shadow_free) return ST_NO_RUN;
        while (cur < NUM_PAGES && steps < NUM_PAGES) begin
            blk_prev = prev;
            blk_start = cur;
            len = 1;
            broke = 0;
            while (len != n && steps < NUM_PAGES && !broke) begin
                nx = shadow_link[cur];
                if (nx >= NUM_PAGES || nx + 1 != cur) begin
                    broke = 1;
                end else begin
                    prev = cur;
                    cur = nx;
                    len++;
                    steps++;
                end
            end
            if (len == n) begin
                if (blk_prev < NUM_PAGES) shadow_link[blk_prev] = shadow_link[cur];
                else shadow_head = shadow_link[cur];
                shadow_link[cur] = NUM_PAGES;
                shadow_free -= n;
                top_page = blk_start;
                return ST_OK;
            end
            prev = cur;
            cur = shadow_link[cur];
            steps++;
        end
        return ST_NO_RUN;
    endfunction

    // Apply one input item to the shadow state and build the result it should give.
    function automatic pfl_out_t apply_page_action(input pfl_in_t req);
        pfl_out_t rsp;
        int n;
        int hi;
        int lo;
        int top_page;
        n = int'(req.count);
        hi = int'(req.page);
        top_page = 0;
        rsp.status = ST_BAD_ARG;
        case (req.action)
            ACT_ALLOC: begin
                rsp.status = claim_run(n, top_page);
            end
            ACT_FREE: begin
                if (n != 0 && n - 1 <= hi) begin
                    lo = hi - (n - 1);
                    if (lo >= range_low && hi <= range_high) begin
                        for (int p = lo; p <= hi; p++) begin
                            shadow_link[p] = shadow_head;
                            shadow_head = p;
                        end
                        shadow_free += n;
                        if (shadow_free > NUM_PAGES) shadow_free = NUM_PAGES;
                        rsp.status = ST_OK;
                    end
                end
            end
            ACT_INIT: begin
                shadow_head = NUM_PAGES;
                shadow_free = 0;
                for (int p = range_low; p <= range_high; p++) begin
                    shadow_link[p] = shadow_head;
                    shadow_head = p;
                    shadow_free++;
                end
                rsp.status = ST_OK;
            end
            default: rsp.status = ST_BAD_ARG;
        endcase
        rsp.page_res = (rsp.status == ST_OK) ? PAGE_W'(top_page) : '0;
        rsp.free_count = COUNT_W'(shadow_free);
        return rsp;
    endfunction

    // Monitor all three channels on the rising edge.
    always @(posedge aclk) begin
        pfl_out_t want;
        if (!aresetn) begin
            foreach (shadow_link[i]) shadow_link[i] = 0;
            shadow_head = NUM_PAGES;
            shadow_free = 0;
            range_low = 0;
            range_high = NUM_PAGES - 1;
            error_count = 0;
            expected_replies.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%t: result item with nothing expected: %p", $realtime, m_data);
                end else begin
                    want = expected_replies.pop_front();
                    if (want.status !== m_data.status || want.page_res !== m_data.page_res ||
                        want.free_count !== m_data.free_count) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("%t: mismatch: expected status %0d page %0d free %0d",
                                     $realtime, want.status, want.page_res, want.free_count,
                                     ", got status %0d page %0d free %0d",
                                     m_data.status, m_data.page_res, m_data.free_count);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_FIRST_PAGE) range_low = int'(cfg_data);
                else range_high = int'(cfg_data);
            end
            if (s_valid && s_ready) expected_replies.push_back(apply_page_action(s_data));
        end
    end

endmodule

### test/testbench.sv
// Top of the page free-list allocator test: clock, reset, stimulus and verdict.
module testbench;
    import pfl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    pfl_in_t           s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    pfl_out_t          m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = CFG_FIRST_PAGE;
    logic [PAGE_W-1:0] cfg_data = '0;
    int                error_count;
    int                outstanding;

    // Runs of pages this side holds, learned from successful allocations.
    int      owned_top [$];
    int      owned_len [$];
    pfl_in_t issued [$];
    int      burst_left = 0;
    int      items_sent = 0;
    int      cur_low = 0;
    int      cur_high = NUM_PAGES - 1;

    always #6 aclk = ~aclk;

    page_free_list_allocator u_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    page_alloc_checker u_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .error_count, .outstanding
    );

    // Record granted runs so that later frees only return pages that are in use.
    always @(posedge aclk) begin
        pfl_in_t req;
        if (aresetn) begin
            if (s_valid && s_ready) issued.push_back(s_data);
            if (m_valid && m_ready && issued.size() != 0) begin
                req = issued.pop_front();
                if (req.action == ACT_ALLOC && m_data.status == ST_OK) begin
                    owned_top.push_back(int'(m_data.page_res));
                    owned_len.push_back(int'(req.count));
                end
            end
        end
    end

    // Receiver stalls follow a mode that changes every so often.
    initial begin
        int mode;
        int left;
        int tick;
        mode = 0;
        left = 0;
        tick = 0;
        forever begin
            @(negedge aclk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            tick++;
            case (mode)
                0: m_ready = 1'b1;
                1: m_ready = $urandom_range(0, 1);
                2: m_ready = ($urandom_range(0, 3) == 0);
                default: m_ready = (tick % 5) < 3;
            endcase
        end
    end

    // Present one item in a burst, with a random gap before a new burst.
    task automatic send_item(input logic [1:0] act, input int pg, input int cnt);
        int gap;
        bit taken;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid = 1'b1;
        s_data.action = act;
        s_data.page = PAGE_W'(pg);
        s_data.count = COUNT_W'(cnt);
        do begin
            @(posedge aclk);
            taken = s_ready;
        end while (!taken);
        @(negedge aclk);
        items_sent++;
    endtask

    // Hold the sender until every result item is back.
    task automatic wait_idle();
        s_valid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input int val);
        bit taken;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = PAGE_W'(val);
        do begin
            @(posedge aclk);
            taken = cfg_ready;
        end while (!taken);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Rebuild the list; what this side held is forgotten.
    task automatic start_list();
        wait_idle();
        owned_top.delete();
        owned_len.delete();
        send_item(ACT_INIT, $urandom_range(0, 1023), $urandom_range(0, 2047));
    endtask

    task automatic set_range(input int lo, input int hi);
        wait_idle();
        write_reg(CFG_FIRST_PAGE, lo);
        write_reg(CFG_LAST_PAGE, hi);
        cur_low = lo;
        cur_high = hi;
        start_list();
    endtask

    // An item that must be refused or that changes nothing.
    task automatic send_noise();
        int pg;
        pg = $urandom_range(0, 1023);
        case ($urandom_range(0, 5))
            0: send_item(2'd3, pg, $urandom_range(0, 2047));
            1: send_item(ACT_ALLOC, pg, 0);
            2: send_item(ACT_FREE, pg, 0);
            3: send_item(ACT_FREE, pg, $urandom_range(pg + 2, 2047));
            4: send_item(ACT_ALLOC, pg, $urandom_range(1025, 2047));
            default: begin
                if (cur_high < 1023) send_item(ACT_FREE, $urandom_range(cur_high + 1, 1023), 1);
                else send_item(ACT_FREE, pg, $urandom_range(pg + 2, 2047));
            end
        endcase
    endtask

    // Return the top part of a held run; the rest stays held.
    task automatic free_held(input bit whole);
        int idx;
        int top;
        int len;
        int k;
        if (owned_top.size() == 0) begin
            send_noise();
        end else begin
            idx = $urandom_range(0, owned_top.size() - 1);
            top = owned_top[idx];
            len = owned_len[idx];
            owned_top.delete(idx);
            owned_len.delete(idx);
            k = whole ? len : $urandom_range(1, len);
            if (k < len) begin
                owned_top.push_back(top - k);
                owned_len.push_back(len - k);
            end
            send_item(ACT_FREE, top, k);
        end
    endtask

    task automatic send_alloc();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 60) n = $urandom_range(1, 4);
        else if (r < 85) n = $urandom_range(5, 32);
        else if (r < 97) n = $urandom_range(33, 300);
        else n = $urandom_range(301, 1024);
        send_item(ACT_ALLOC, $urandom_range(0, 1023), n);
    endtask

    task automatic run_phase(input int lo, input int hi, input int n_items);
        int r;
        set_range(lo, hi);
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) send_alloc();
            else if (r < 85) free_held(r < 60);
            else if (r < 98) send_noise();
            else start_list();
        end
    endtask

    initial begin
        int lo;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: empty list, bad arguments, then the full range at its extremes.
        send_item(ACT_ALLOC, 0, 1);
        send_item(ACT_ALLOC, 1023, 0);
        send_item(2'd3, 1023, 2047);
        start_list();
        send_item(ACT_ALLOC, 0, 1);
        send_item(ACT_ALLOC, 1023, 1024);
        send_item(ACT_ALLOC, 0, 3);
        send_item(ACT_ALLOC, 0, 2047);
        send_item(ACT_FREE, 512, 0);
        send_item(ACT_FREE, 2, 5);
        wait_idle();
        free_held(1);
        send_item(ACT_ALLOC, 0, 1);
        wait_idle();
        free_held(1);
        free_held(1);
        send_item(ACT_ALLOC, 0, 4);

        // Small range: run below the first page and a page above the last.
        set_range(10, 20);
        send_item(ACT_FREE, 12, 5);
        send_item(ACT_FREE, 25, 1);
        send_item(ACT_ALLOC, 0, 11);
        send_item(ACT_ALLOC, 0, 12);
        set_range(30, 5);
        send_item(ACT_ALLOC, 0, 1);
        set_range(1023, 1023);
        send_item(ACT_ALLOC, 0, 1);
        wait_idle();
        free_held(1);
        set_range(0, 0);
        send_item(ACT_ALLOC, 0, 1);
        wait_idle();
        free_held(1);
        send_item(ACT_ALLOC, 0, 2);

        // Random phases over several ranges, extremes first.
        run_phase(0, 1023, 120);
        run_phase(0, 63, 80);
        run_phase(960, 1023, 80);
        run_phase(1023, 1023, 40);
        run_phase(0, 0, 40);
        run_phase(600, 200, 30);
        run_phase(100, 227, 80);
        while (items_sent < 1900) begin
            lo = $urandom_range(0, 1023);
            run_phase(lo, (lo + $urandom_range(0, 80)) % 1024, $urandom_range(40, 90));
        end

        wait_idle();
        repeat (20) @(negedge aclk);
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Watchdog over the whole run, sized for every item walking the full list.
    initial begin
        #300ms;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

### filelist.f
rtl/pfl_pkg.sv
rtl/page_free_list_allocator.sv
test/page_alloc_checker.sv
test/testbench.sv
